@@ design/single_source_shortest_path_core_defines.svh @@
// Assertion macros shared by the checker
`ifndef SINGLE_SOURCE_SHORTEST_PATH_CORE_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssp assertion failed");

// Next-cycle implication, disabled during reset
`define SSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssp assertion failed");

`endif

@@ design/ssp_pkg.sv @@
`default_nettype none
package ssp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int WEIGHT_BITS  = 16;

    localparam int VTX_W   = $clog2(MAX_VERTICES);
    localparam int VCNT_W  = 7;
    localparam int EADDR_W = $clog2(MAX_EDGES);
    localparam int CNT_W   = EADDR_W + 1;
    localparam int DIST_W  = 22;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic              reached;
        logic              settled;
        logic [DIST_W-1:0] path_len;
    } vtx_t;

    typedef struct packed {
        logic [VTX_W-1:0]       a;
        logic [VTX_W-1:0]       b;
        logic [WEIGHT_BITS-1:0] w;
    } edge_t;

    typedef struct packed {
        logic accept;
        logic idx_clr;
        logic idx_inc;
        logic init_wr;
        logic src_wr;
        logic pick_clr;
        logic scan_rd;
        logic scan_eval;
        logic settle_wr;
        logic edge_rd;
        logic edge_eval;
        logic relax_wr;
        logic out_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_run;
        logic init_end;
        logic src_bad;
        logic idx_end;
        logic edge_end;
        logic pick_none;
        logic out_last;
    } stat_t;

endpackage
`default_nettype wire

@@ design/ssp_if.sv @@
`default_nettype none
interface ssp_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      operation;
    logic [ssp_pkg::VTX_W-1:0]       first_node;
    logic [ssp_pkg::VTX_W-1:0]       second_node;
    logic [15:0]                     edge_weight;
    logic [ssp_pkg::VTX_W-1:0]       source_vertex;

    modport source (output valid, operation, first_node, second_node, edge_weight,
                    source_vertex, input ready);
    modport sink (input valid, operation, first_node, second_node, edge_weight,
                  source_vertex, output ready);
endinterface

interface ssp_out_if;
    logic                        valid;
    logic                        ready;
    logic [ssp_pkg::VTX_W-1:0]   vertex_index;
    logic [ssp_pkg::DIST_W-1:0]  distance;
    logic                        unreachable;
    logic                        store_overflow;
    logic                        last;

    modport source (output valid, vertex_index, distance, unreachable, store_overflow,
                    last, input ready);
    modport sink (input valid, vertex_index, distance, unreachable, store_overflow,
                  last, output ready);
endinterface
`default_nettype wire

@@ design/ssp_ctrl.sv @@
`default_nettype none
module ssp_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire ssp_pkg::stat_t stat,
    output ssp_pkg::cmd_t       cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b000000000001,
        S_INIT     = 12'b000000000010,
        S_SRC      = 12'b000000000100,
        S_SCAN_RD  = 12'b000000001000,
        S_SCAN_EV  = 12'b000000010000,
        S_EDGE_RD  = 12'b000000100000,
        S_EDGE_EV  = 12'b000001000000,
        S_RELAX    = 12'b000010000000,
        S_OUT_RD   = 12'b000100000000,
        S_OUT_LD   = 12'b001000000000,
        S_OUT_SEND = 12'b010000000000,
        S_SPARE    = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && stat.in_run)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                cmd.idx_inc = 1'b1;
                if (stat.init_end)
                begin
                    cmd.idx_inc = 1'b0;
                    cmd.idx_clr = 1'b1;
                    state_next  = S_SRC;
                end
            end
            S_SRC:
            begin
                cmd.idx_clr  = 1'b1;
                cmd.pick_clr = 1'b1;
                if (stat.src_bad)
                begin
                    state_next = S_OUT_RD;
                end
                else
                begin
                    cmd.src_wr = 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.idx_end)
                begin
                    cmd.idx_clr = 1'b1;
                    if (stat.pick_none)
                    begin
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        cmd.settle_wr = 1'b1;
                        state_next    = S_EDGE_RD;
                    end
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = S_SCAN_EV;
                end
            end
            S_SCAN_EV:
            begin
                cmd.scan_eval = 1'b1;
                cmd.idx_inc   = 1'b1;
                state_next    = S_SCAN_RD;
            end
            S_EDGE_RD:
            begin
                if (stat.edge_end)
                begin
                    cmd.idx_clr  = 1'b1;
                    cmd.pick_clr = 1'b1;
                    state_next   = S_SCAN_RD;
                end
                else
                begin
                    cmd.edge_rd = 1'b1;
                    state_next  = S_EDGE_EV;
                end
            end
            S_EDGE_EV:
            begin
                cmd.edge_eval = 1'b1;
                cmd.idx_inc   = 1'b1;
                state_next    = S_RELAX;
            end
            S_RELAX:
            begin
                cmd.relax_wr = 1'b1;
                state_next   = S_EDGE_RD;
            end
            S_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OUT_SEND;
            end
            S_OUT_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (stat.out_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ design/ssp_dp.sv @@
`default_nettype none
module ssp_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [ssp_pkg::VCNT_W-1:0]    wr_data,
    input  wire logic [1:0]                    operation,
    input  wire logic [ssp_pkg::VTX_W-1:0]     first_node,
    input  wire logic [ssp_pkg::VTX_W-1:0]     second_node,
    input  wire logic [15:0]                   edge_weight,
    input  wire logic [ssp_pkg::VTX_W-1:0]     source_vertex,
    input  wire ssp_pkg::cmd_t                 cmd,
    output ssp_pkg::stat_t                     stat,
    output logic [ssp_pkg::VTX_W-1:0]          vertex_index,
    output logic [ssp_pkg::DIST_W-1:0]         distance,
    output logic                               unreachable,
    output logic                               store_overflow,
    output logic                               last
);

    localparam int VW = ssp_pkg::VTX_W;
    localparam int CW = ssp_pkg::CNT_W;
    localparam int DW = ssp_pkg::DIST_W;

    ssp_pkg::edge_t edge_mem [ssp_pkg::MAX_EDGES];
    ssp_pkg::vtx_t  vtx_mem  [ssp_pkg::MAX_VERTICES];

    logic [ssp_pkg::VCNT_W-1:0] vcount_reg;
    logic [CW-1:0]              edge_total_reg;
    logic                       overflow_reg;
    logic [CW-1:0]              idx_reg;
    logic [VW-1:0]              src_reg;
    logic                       pick_valid_reg;
    logic [VW-1:0]              pick_idx_reg;
    logic [DW-1:0]              pick_d_reg;
    ssp_pkg::edge_t             erd_reg;
    ssp_pkg::vtx_t              vrd_reg;
    logic                       hit_reg;
    logic [VW-1:0]              tgt_reg;
    logic [ssp_pkg::WEIGHT_BITS-1:0] w_reg;
    logic                       last_reg;

    logic [ssp_pkg::VCNT_W-1:0] n_act;
    logic                       add_drop;
    logic                       e_ok, e_a_hit, e_b_hit;
    logic [VW-1:0]              e_tgt;
    logic [DW:0]                cand;
    logic [DW-1:0]              cand_sat;
    logic                       vwr_en;
    logic [VW-1:0]              vwr_addr;
    ssp_pkg::vtx_t              vwr_data;
    logic                       vrd_en;
    logic [VW-1:0]              vrd_addr;

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_act = ssp_pkg::VCNT_W'(1);
        end
        else if (vcount_reg > ssp_pkg::VCNT_W'(ssp_pkg::MAX_VERTICES))
        begin
            n_act = ssp_pkg::VCNT_W'(ssp_pkg::MAX_VERTICES);
        end
        else
        begin
            n_act = vcount_reg;
        end
    end

    assign add_drop = (edge_total_reg >= CW'(ssp_pkg::MAX_EDGES))
                   || ({1'b0, first_node} >= n_act) || ({1'b0, second_node} >= n_act);

    // Edge endpoints are tested against the count in force for this run
    assign e_ok    = ({1'b0, erd_reg.a} < n_act) && ({1'b0, erd_reg.b} < n_act);
    assign e_a_hit = erd_reg.a == pick_idx_reg;
    assign e_b_hit = erd_reg.b == pick_idx_reg;
    assign e_tgt   = e_a_hit ? erd_reg.b : erd_reg.a;

    assign cand     = {1'b0, pick_d_reg} + (DW+1)'(w_reg);
    assign cand_sat = cand[DW] ? ssp_pkg::DIST_MAX : cand[DW-1:0];

    always_comb
    begin
        vwr_en   = 1'b0;
        vwr_addr = idx_reg[VW-1:0];
        vwr_data = '0;
        if (cmd.init_wr)
        begin
            vwr_en = 1'b1;
        end
        else if (cmd.src_wr)
        begin
            vwr_en           = 1'b1;
            vwr_addr         = src_reg;
            vwr_data.reached = 1'b1;
        end
        else if (cmd.settle_wr)
        begin
            vwr_en   = 1'b1;
            vwr_addr = pick_idx_reg;
            vwr_data = '{reached: 1'b1, settled: 1'b1, path_len: pick_d_reg};
        end
        else if (cmd.relax_wr)
        begin
            vwr_addr = tgt_reg;
            vwr_data = '{reached: 1'b1, settled: 1'b0, path_len: cand_sat};
            vwr_en   = hit_reg && !vrd_reg.settled
                    && (!vrd_reg.reached || (cand_sat < vrd_reg.path_len));
        end
    end

    assign vrd_en   = cmd.scan_rd || cmd.out_rd || cmd.edge_eval;
    assign vrd_addr = cmd.edge_eval ? e_tgt : idx_reg[VW-1:0];

    always_ff @(posedge clk)
    begin
        if (vwr_en)
        begin
            vtx_mem[vwr_addr] <= vwr_data;
        end
        if (vrd_en)
        begin
            vrd_reg <= vtx_mem[vrd_addr];
        end
        if (cmd.accept && operation == ssp_pkg::OP_ADD && !add_drop)
        begin
            edge_mem[edge_total_reg[ssp_pkg::EADDR_W-1:0]] <=
                '{a: first_node, b: second_node, w: edge_weight[ssp_pkg::WEIGHT_BITS-1:0]};
        end
        if (cmd.edge_rd)
        begin
            erd_reg <= edge_mem[idx_reg[ssp_pkg::EADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg     <= ssp_pkg::VCNT_W'(ssp_pkg::MAX_VERTICES);
            edge_total_reg <= '0;
            overflow_reg   <= 1'b0;
            idx_reg        <= '0;
            pick_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vcount_reg <= wr_data;
            end
            if (cmd.accept)
            begin
                if (operation == ssp_pkg::OP_ADD)
                begin
                    if (add_drop)
                    begin
                        overflow_reg <= 1'b1;
                    end
                    else
                    begin
                        edge_total_reg <= edge_total_reg + CW'(1);
                    end
                end
                else if (operation == ssp_pkg::OP_CLEAR)
                begin
                    edge_total_reg <= '0;
                    overflow_reg   <= 1'b0;
                end
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (cmd.pick_clr)
            begin
                pick_valid_reg <= 1'b0;
            end
            else if (cmd.scan_eval && vrd_reg.reached && !vrd_reg.settled
                     && (!pick_valid_reg || vrd_reg.path_len < pick_d_reg))
            begin
                pick_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && operation == ssp_pkg::OP_RUN)
        begin
            src_reg <= source_vertex;
        end
        if (cmd.scan_eval && vrd_reg.reached && !vrd_reg.settled
            && (!pick_valid_reg || vrd_reg.path_len < pick_d_reg))
        begin
            pick_idx_reg <= idx_reg[VW-1:0];
            pick_d_reg   <= vrd_reg.path_len;
        end
        if (cmd.edge_eval)
        begin
            // A self loop touches only the settled vertex: skip it
            hit_reg <= e_ok && (e_a_hit != e_b_hit);
            tgt_reg <= e_tgt;
            w_reg   <= erd_reg.w;
        end
        if (cmd.out_load)
        begin
            vertex_index   <= idx_reg[VW-1:0];
            distance       <= vrd_reg.reached ? vrd_reg.path_len : '0;
            unreachable    <= !vrd_reg.reached;
            store_overflow <= overflow_reg;
            last_reg       <= (idx_reg + CW'(1)) == CW'(n_act);
        end
    end

    assign last = last_reg;

    assign stat.in_run    = operation == ssp_pkg::OP_RUN;
    assign stat.init_end  = idx_reg == CW'(ssp_pkg::MAX_VERTICES - 1);
    assign stat.src_bad   = {1'b0, src_reg} >= n_act;
    assign stat.idx_end   = idx_reg == CW'(n_act);
    assign stat.edge_end  = idx_reg == edge_total_reg;
    assign stat.pick_none = !pick_valid_reg;
    assign stat.out_last  = last_reg;

endmodule
`default_nettype wire

@@ design/single_source_shortest_path_core.sv @@
// Single-source shortest path engine (Dijkstra over a stored edge list).
// Request channel (req): operation add edge loads first_node/second_node/
//   edge_weight into the edge store, or drops it and sets the overflow flag
//   if the store is full or an endpoint is out of range; clear empties the
//   store and the overflow flag; run starts a search from source_vertex.
// Result channel (result): one response per vertex 0..vertex_count-1 in index
//   order (vertex_count taken as 1 when 0 and as 64 above 64), with last on
//   the final one and the sticky store_overflow flag.
// Configuration: wr_en/wr_data write vertex_count; write only while idle.
// Run: clear all 64 vertex table entries and seed the source; then, per
//   settled vertex, scan the N vertices in use for the minimum and relax each
//   of the E stored edges; end with a final scan and the results. Run time is
//   set by the single-port edge store and vertex table, one entry per step.
// req.ready is high only while the engine is idle; no request is taken
//   during a run or while results are being delivered.
// When the receiver stalls, the current result holds on the port until taken.
// Reset clears the edge count, the overflow flag and the controller, and sets
//   vertex_count to 64; the stores need no clearing pass.
`default_nettype none
module single_source_shortest_path_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [ssp_pkg::VCNT_W-1:0]  wr_data,
    ssp_in_if.sink                           req,
    ssp_out_if.source                        result
);

    ssp_pkg::cmd_t  cmd;
    ssp_pkg::stat_t stat;

    // Sequence the run: clear, scan, settle, relax, deliver
    ssp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the edge store, vertex table and result register
    ssp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_data        (wr_data),
        .operation      (req.operation),
        .first_node     (req.first_node),
        .second_node    (req.second_node),
        .edge_weight    (req.edge_weight),
        .source_vertex  (req.source_vertex),
        .cmd            (cmd),
        .stat           (stat),
        .vertex_index   (result.vertex_index),
        .distance       (result.distance),
        .unreachable    (result.unreachable),
        .store_overflow (result.store_overflow),
        .last           (result.last)
    );

endmodule
`default_nettype wire

@@ design/ssp_checker.sv @@
`default_nettype none
`include "single_source_shortest_path_core_defines.svh"
module ssp_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic [1:0]                  in_op,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [ssp_pkg::VTX_W-1:0]   out_index,
    input wire logic [ssp_pkg::DIST_W-1:0]  out_dist,
    input wire logic                        out_unreach
);

    `SSP_ASSERT_NOW(a_no_req_while_result, out_valid, !in_ready)
    `SSP_ASSERT_NEXT(a_run_blocks_req, in_valid && in_ready && in_op == ssp_pkg::OP_RUN, !in_ready)
    `SSP_ASSERT_NOW(a_unreach_zero, out_valid && out_unreach, out_dist == '0)
    `SSP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_index))

endmodule

bind single_source_shortest_path_core ssp_checker u_ssp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .in_op       (req.operation),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_index   (result.vertex_index),
    .out_dist    (result.distance),
    .out_unreach (result.unreachable)
);
`default_nettype wire
